>>> hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the first-fit frame allocator.
// No dependencies; compiled first.
package ffa_pkg;

   // Count and frame-number width covering the largest supported map (4096 frames).
   localparam int CNT_W      = 13;
   localparam int NP_W       = 7;   // page_count and recorded run length
   localparam int FI_W       = 6;   // frame_index and start_frame
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_DATA_W-1:0] FRAME_COUNT_RST = 7'd64;

   typedef enum logic {
      OP_ALLOC,
      OP_FREE
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_REUSED,
      ST_FRESH,
      ST_NOSPACE,
      ST_BAD
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COUNT,
      CSR_FIRST_UNCLAIMED,
      CSR_TABLE_ACTIVE
   } csr_idx_type;

   // Token handed from cell to cell, one hop per cycle.
   typedef struct packed {
      logic             act;
      op_type           op;
      logic [NP_W-1:0]  np;
      logic [FI_W-1:0]  fi;
      logic [NP_W-1:0]  run;      // current free run, saturating
      logic [NP_W-1:0]  remain;   // frames still to mark on a free
      logic             found;
      logic [CNT_W-1:0] first;
   } link_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic             clr_en;   // mark [lo, lo+np) busy
      logic             len_we;   // record np as run length at lo
      logic [CNT_W-1:0] lo;
      logic [NP_W-1:0]  np;
      logic [CNT_W-1:0] usable;
   } cmd_type;

endpackage

>>> hw/rtl/ffa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the frame allocator: request, response, CSR write.
// Depends on nothing; widths match ffa_pkg.
interface ffa_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [6:0] page_count;
   logic [5:0] frame_index;
   modport source (output valid, op, page_count, frame_index, input ready);
   modport sink   (input valid, op, page_count, frame_index, output ready);
endinterface

interface ffa_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [5:0] base_frame;
   modport source (output valid, status, base_frame, input ready);
   modport sink   (input valid, status, base_frame, output ready);
endinterface

interface ffa_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/first_fit_frame_allocator.sv
`timescale 1ns / 1ps
// Path, request accept to response valid: DISPATCH then FINISH for a rejected request, a free with
//   the table off, or a bump-only allocate; SCAN between them when the token walks the cell row.
// Throughput: one item at a time; the next request is taken in the same cycle the response goes
//   valid. FINISH waits while the output register still holds an unaccepted response.
// Reset (synchronous, active high) marks every frame busy, clears all run lengths, loads
//   frame_count 64, table on, bump pointer 0. No clearing pass; CSR port is always ready.
module first_fit_frame_allocator #(
   parameter int NUM_FRAMES = 64
) (
   input logic       clock,
   input logic       reset,
   ffa_req_if.sink   req_ch,
   ffa_rsp_if.source rsp_ch,
   ffa_csr_if.sink   csr_ch
);
   import ffa_pkg::*;

   localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(NUM_FRAMES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,   // decide: answer at once or launch the token
      S_SCAN,       // token walking the cells
      S_FINISH      // result waits for the output register
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [NP_W-1:0]       np_ff, np_in;
   logic [FI_W-1:0]       fi_ff, fi_in;
   logic [CSR_DATA_W-1:0] fc_ff, fc_in;
   logic                  tbl_ff, tbl_in;
   logic [CNT_W-1:0]      bump_ff, bump_in;
   status_type            res_status_ff, res_status_in;
   logic [FI_W-1:0]       res_start_ff, res_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [FI_W-1:0]       rsp_start_ff, rsp_start_in;

   logic [CNT_W-1:0]      fc_ext;
   logic [CNT_W-1:0]      usable;
   logic [CNT_W-1:0]      np_ext;
   logic                  bump_ok;
   link_type              inject;
   link_type              tail;
   cmd_type               cmd;
   link_type              links [NUM_FRAMES+1];

   // usable = min(frame_count, NUM_FRAMES)
   assign fc_ext  = CNT_W'(fc_ff);
   assign usable  = (fc_ext > FRAMES_C) ? FRAMES_C : fc_ext;
   assign np_ext  = CNT_W'(np_ff);
   assign bump_ok = (bump_ff < usable) && (np_ext <= usable - bump_ff);
   assign tail    = links[NUM_FRAMES];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      np_in         = np_ff;
      fi_in         = fi_ff;
      fc_in         = fc_ff;
      tbl_in        = tbl_ff;
      bump_in       = bump_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;

      inject        = '0;
      inject.op     = op_ff;
      inject.np     = np_ff;
      inject.fi     = fi_ff;

      cmd           = '0;
      cmd.np        = np_ff;
      cmd.usable    = usable;

      // output register drains first; FINISH may refill it in the same cycle
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = op_type'(req_ch.op);
               np_in    = req_ch.page_count;
               fi_in    = req_ch.frame_index;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_start_in = '0;
            state_in     = S_FINISH;
            if (op_ff == OP_ALLOC) begin
               if (np_ff == '0) begin
                  res_status_in = ST_BAD;
               end else if (tbl_ff) begin
                  inject.act = 1'b1;
                  state_in   = S_SCAN;
               end else if (bump_ok) begin
                  // bump only: no run length recorded
                  bump_in       = bump_ff + np_ext;
                  res_status_in = ST_FRESH;
                  res_start_in  = bump_ff[FI_W-1:0];
               end else begin
                  res_status_in = ST_NOSPACE;
               end
            end else begin
               if (!tbl_ff) begin
                  res_status_in = ST_REUSED;
               end else if (CNT_W'(fi_ff) >= usable) begin
                  res_status_in = ST_BAD;
               end else begin
                  inject.act = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (tail.act) begin
               state_in     = S_FINISH;
               res_start_in = '0;
               if (op_ff == OP_FREE) begin
                  res_status_in = ST_REUSED;
               end else if (tail.found) begin
                  // reuse the lowest free run: mark it busy, record its length
                  cmd.clr_en    = 1'b1;
                  cmd.len_we    = 1'b1;
                  cmd.lo        = tail.first;
                  res_status_in = ST_REUSED;
                  res_start_in  = tail.first[FI_W-1:0];
               end else if (bump_ok) begin
                  cmd.len_we    = 1'b1;
                  cmd.lo        = bump_ff;
                  bump_in       = bump_ff + np_ext;
                  res_status_in = ST_FRESH;
                  res_start_in  = bump_ff[FI_W-1:0];
               end else begin
                  res_status_in = ST_NOSPACE;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = S_IDLE;
            end
         end
      endcase

      // CSR writes apply in any state; the sender keeps them clear of items in flight
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_FRAME_COUNT:     fc_in   = csr_ch.data;
            CSR_FIRST_UNCLAIMED: bump_in = CNT_W'(csr_ch.data);
            CSR_TABLE_ACTIVE:    tbl_in  = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= FRAME_COUNT_RST;
         tbl_ff       <= 1'b1;
         bump_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fc_ff        <= fc_in;
         tbl_ff       <= tbl_in;
         bump_ff      <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      np_ff         <= np_in;
      fi_ff         <= fi_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   // row of frame cells; the token enters at cell 0 and leaves after the last
   assign links[0] = inject;

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      ffa_cell #(
         .INDEX(g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_link   (links[g]),
         .cmd       (cmd),
         .down_link (links[g+1])
      );
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.base_frame = rsp_start_ff;
   assign csr_ch.ready      = 1'b1;

endmodule

>>> hw/rtl/ffa_cell.sv
`timescale 1ns / 1ps
// One frame of the allocator: free bit, recorded run length, and one token stage.
// Depends on ffa_pkg.
module ffa_cell #(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  ffa_pkg::link_type up_link,
   input  ffa_pkg::cmd_type  cmd,
   output ffa_pkg::link_type down_link
);
   import ffa_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic              free_ff, free_in;
   logic [NP_W-1:0]   len_ff, len_in;
   link_type          link_ff, link_in;

   logic              in_range;
   logic              at_start;
   logic [NP_W:0]     run_inc;
   logic [NP_W-1:0]   run_nx;
   logic [NP_W-1:0]   cnt;
   logic [CNT_W-1:0]  np_ext;

   always_comb begin
      free_in  = free_ff;
      len_in   = len_ff;
      link_in  = up_link;
      in_range = IDX < cmd.usable;
      np_ext   = CNT_W'(cmd.np);
      run_inc  = (NP_W+1)'(up_link.run) + (NP_W+1)'(1);
      run_nx   = free_ff ? (run_inc[NP_W] ? '1 : run_inc[NP_W-1:0]) : '0;
      at_start = IDX == CNT_W'(up_link.fi);
      cnt      = at_start ? len_ff : up_link.remain;

      if (up_link.act && in_range) begin
         unique case (up_link.op)
            OP_ALLOC: begin
               if (!up_link.found) begin
                  link_in.run = run_nx;
                  if (free_ff && run_nx >= up_link.np) begin
                     link_in.found = 1'b1;
                     link_in.first = IDX + CNT_W'(1) - CNT_W'(up_link.np);
                  end
               end
            end
            OP_FREE: begin
               link_in.remain = cnt;
               if (cnt != '0) begin
                  free_in        = 1'b1;
                  link_in.remain = cnt - NP_W'(1);
               end
            end
         endcase
      end

      if (cmd.clr_en && IDX >= cmd.lo && IDX < cmd.lo + np_ext) begin
         free_in = 1'b0;
      end
      if (cmd.len_we && IDX == cmd.lo) begin
         len_in = cmd.np;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b0;
         len_ff  <= '0;
         link_ff <= '0;
      end else begin
         free_ff <= free_in;
         len_ff  <= len_in;
         link_ff <= link_in;
      end
   end

   assign down_link = link_ff;

endmodule

>>> hw/rtl/ffa_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the frame allocator, and the bind that attaches them.
// Depends on ffa_pkg and first_fit_frame_allocator.
module ffa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_base_frame
);
   import ffa_pkg::*;

   // one item in flight: no back-to-back accepts
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item still in progress");

   // a fresh response is only produced while the request side is busy
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without an item in progress");

   // failures carry start frame zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOSPACE || rsp_status == ST_BAD)
         |-> rsp_base_frame == '0)
      else $error("failed response with nonzero start frame");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_base_frame))
      else $error("stalled response beat changed");

endmodule

bind first_fit_frame_allocator ffa_checker u_ffa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_base_frame (rsp_ch.base_frame)
);
